// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising clock edge out of reset
`define CTAU_ASSERT(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) else $error(msg);

// same-cycle implication
`define CTAU_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTAU_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ctau_pkg.sv =====
// shared types and constants of the color to alpha block
`default_nettype none
package ctau_pkg;
    localparam int CH_W      = 8;
    localparam int ALPHA_W   = 17;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CH_N      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BG_RED   = 2'd0,
        CFG_BG_GREEN = 2'd1,
        CFG_BG_BLUE  = 2'd2
    } cfg_idx_t;

    // valid marker carried along a divider row
    typedef struct packed {
        logic valid;
    } ctau_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/ctau_div_cell.sv =====
// one restoring division step, registered, with sideband pass-along
`default_nettype none
module ctau_div_cell #(
    parameter int RW    = 24,
    parameter int DW    = 8,
    parameter int QW    = 17,
    parameter int SW    = 18,
    parameter int SHIFT = 0
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  ctau_pkg::ctau_ctl_t in_ctl,
    input  wire  [RW-1:0]       in_rem,
    input  wire  [DW-1:0]       in_den,
    input  wire  [QW-1:0]       in_quot,
    input  wire  [SW-1:0]       in_side,
    output ctau_pkg::ctau_ctl_t out_ctl,
    output logic [RW-1:0]       out_rem,
    output logic [DW-1:0]       out_den,
    output logic [QW-1:0]       out_quot,
    output logic [SW-1:0]       out_side
);
    import ctau_pkg::*;

    ctau_ctl_t     ctl_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] quot_reg, quot_next;
    logic [SW-1:0] side_reg;
    logic [RW-1:0] den_sh;
    logic          fits;

    // divisor aligned to this step's quotient bit
    assign den_sh    = RW'(in_den) << SHIFT;
    assign fits      = in_rem >= den_sh;
    assign rem_next  = fits ? (in_rem - den_sh) : in_rem;
    assign quot_next = {in_quot[QW-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= in_den;
        quot_reg <= quot_next;
        side_reg <= in_side;
    end

    assign out_ctl  = ctl_reg;
    assign out_rem  = rem_reg;
    assign out_den  = den_reg;
    assign out_quot = quot_reg;
    assign out_side = side_reg;
endmodule
`default_nettype wire

// ===== rtl/core/ctau_div_chain.sv =====
// row of division cells, one quotient bit per cell
`default_nettype none
module ctau_div_chain #(
    parameter int RW = 24,
    parameter int DW = 8,
    parameter int QW = 17,
    parameter int SW = 18
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  ctau_pkg::ctau_ctl_t in_ctl,
    input  wire  [RW-1:0]       in_rem,
    input  wire  [DW-1:0]       in_den,
    input  wire  [SW-1:0]       in_side,
    output ctau_pkg::ctau_ctl_t out_ctl,
    output logic [QW-1:0]       out_quot,
    output logic [SW-1:0]       out_side
);
    import ctau_pkg::*;

    ctau_ctl_t     ctl  [QW+1];
    logic [RW-1:0] rem  [QW+1];
    logic [DW-1:0] den  [QW+1];
    logic [QW-1:0] quot [QW+1];
    logic [SW-1:0] side [QW+1];

    assign ctl[0]  = in_ctl;
    assign rem[0]  = in_rem;
    assign den[0]  = in_den;
    assign quot[0] = '0;
    assign side[0] = in_side;

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        ctau_div_cell #(
            .RW(RW), .DW(DW), .QW(QW), .SW(SW), .SHIFT(QW - 1 - i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_ctl   (ctl[i]),
            .in_rem   (rem[i]),
            .in_den   (den[i]),
            .in_quot  (quot[i]),
            .in_side  (side[i]),
            .out_ctl  (ctl[i+1]),
            .out_rem  (rem[i+1]),
            .out_den  (den[i+1]),
            .out_quot (quot[i+1]),
            .out_side (side[i+1])
        );
    end

    assign out_ctl  = ctl[QW];
    assign out_quot = quot[QW];
    assign out_side = side[QW];
endmodule
`default_nettype wire

// ===== rtl/core/color_to_alpha_unmix_top.sv =====
// top level: background color removal, one rgb word in, one rgba word out
//
//  channel   handshake        payload
//  pixel in  start / busy     red, green, blue
//  result    done (strobe)    out_red, out_green, out_blue, out_alpha
//  config    cfg_we           cfg_index, cfg_data
//
// one word accepted every cycle; busy is never raised
// the path: 17 alpha divider cells, max stage, product stage,
// 9 unmix divider cells and the output register
// the divider rows are fully pipelined, so the rate is set by one cell step
// reset puts the background at white and empties the pipeline
// the result is shown for one cycle only, the receiver cannot stall
`default_nettype none
`include "assert_macros.svh"
module color_to_alpha_unmix_top (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire  [7:0]                         red,
    input  wire  [7:0]                         green,
    input  wire  [7:0]                         blue,
    input  wire                                cfg_we,
    input  wire  [ctau_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [7:0]                         cfg_data,
    output logic                               done,
    output logic [7:0]                         out_red,
    output logic [7:0]                         out_green,
    output logic [7:0]                         out_blue,
    output logic [7:0]                         out_alpha
);
    import ctau_pkg::*;

    localparam int A_RW = 24;
    localparam int A_SW = 2 * CH_W + 2;
    localparam int U_RW = 27;
    localparam int U_DW = ALPHA_W;
    localparam int U_QW = 9;
    localparam int U_SW = 2 * CH_W + 3;

    // background registers
    logic [CH_W-1:0] bg_reg [CH_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH_N; i++)
            begin
                bg_reg[i] <= '1;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BG_RED:   bg_reg[0] <= cfg_data;
                CFG_BG_GREEN: bg_reg[1] <= cfg_data;
                CFG_BG_BLUE:  bg_reg[2] <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic [CH_W-1:0] pix [CH_N];
    assign pix[0] = red;
    assign pix[1] = green;
    assign pix[2] = blue;

    ctau_ctl_t in_ctl;
    assign in_ctl.valid = start;

    // channel alpha dividers
    ctau_ctl_t       a_ctl  [CH_N];
    logic [ALPHA_W-1:0] a_quot [CH_N];
    logic [A_SW-1:0] a_side [CH_N];
    logic [ALPHA_W-1:0] ch_alpha [CH_N];

    for (genvar c = 0; c < CH_N; c++)
    begin : g_alpha
        logic            gt;
        logic [CH_W-1:0] num, den;
        logic [A_RW-1:0] dvd;
        logic            eq_o, den0_o;

        // darker: (b-c)/b, lighter: (c-b)/(255-b), half divisor for rounding
        assign gt  = pix[c] > bg_reg[c];
        assign num = gt ? (pix[c] - bg_reg[c]) : (bg_reg[c] - pix[c]);
        assign den = gt ? (8'd255 - bg_reg[c]) : bg_reg[c];
        assign dvd = {num, 16'b0} + A_RW'(den >> 1);

        ctau_div_chain #(.RW(A_RW), .DW(CH_W), .QW(ALPHA_W), .SW(A_SW)) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_ctl   (in_ctl),
            .in_rem   (dvd),
            .in_den   (den),
            .in_side  ({pix[c], bg_reg[c], pix[c] == bg_reg[c], den == '0}),
            .out_ctl  (a_ctl[c]),
            .out_quot (a_quot[c]),
            .out_side (a_side[c])
        );

        assign eq_o   = a_side[c][1];
        assign den0_o = a_side[c][0];
        // equal to background is transparent, zero divisor is fully opaque
        assign ch_alpha[c] = eq_o ? '0 : (den0_o ? ALPHA_W'(1 << FRAC_W) : a_quot[c]);
    end

    // max of channel alphas
    logic [ALPHA_W-1:0] max_rg, max_all;
    assign max_rg  = (ch_alpha[0] > ch_alpha[1]) ? ch_alpha[0] : ch_alpha[1];
    assign max_all = (ch_alpha[2] > max_rg) ? ch_alpha[2] : max_rg;

    logic               m_valid_reg;
    logic [ALPHA_W-1:0] m_alpha_reg;
    logic [CH_W-1:0]    m_pix_reg [CH_N];
    logic [CH_W-1:0]    m_bg_reg  [CH_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= a_ctl[0].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        m_alpha_reg <= max_all;
        for (int i = 0; i < CH_N; i++)
        begin
            m_pix_reg[i] <= a_side[i][A_SW-1 -: CH_W];
            m_bg_reg[i]  <= a_side[i][2 +: CH_W];
        end
    end

    // product stage: t = 2*((c-b)*2^16 + b*a) + a, and the scaled alpha
    logic                p_valid_reg;
    logic signed [28:0]  p_t_reg   [CH_N];
    logic [CH_W-1:0]     p_pix_reg [CH_N];
    logic [ALPHA_W-1:0]  p_alpha_reg;
    logic [CH_W-1:0]     p_oa_reg;
    logic [24:0]         oa_prod;
    logic signed [28:0]  t_next [CH_N];

    assign oa_prod = 25'(m_alpha_reg) * 25'd255 + 25'd32768;

    for (genvar c = 0; c < CH_N; c++)
    begin : g_prod
        logic signed [8:0]  diff;
        logic signed [28:0] dext;
        logic [24:0]        bprod;
        assign diff  = $signed({1'b0, m_pix_reg[c]}) - $signed({1'b0, m_bg_reg[c]});
        assign dext  = 29'(diff);
        assign bprod = 25'(m_bg_reg[c]) * 25'(m_alpha_reg);
        assign t_next[c] = ((dext <<< 16) + $signed({4'b0, bprod})) * 29'sd2
                           + $signed({12'b0, m_alpha_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_alpha_reg <= m_alpha_reg;
        p_oa_reg    <= oa_prod[23:16];
        for (int i = 0; i < CH_N; i++)
        begin
            p_t_reg[i]   <= t_next[i];
            p_pix_reg[i] <= m_pix_reg[i];
        end
    end

    // unmix dividers: quotient of t by 2a
    logic            p_bypass;
    logic [U_DW-1:0] u_den;
    ctau_ctl_t       p_ctl;
    ctau_ctl_t       u_ctl  [CH_N];
    logic [U_QW-1:0] u_quot [CH_N];
    logic [U_SW-1:0] u_side [CH_N];
    logic [CH_W-1:0] res    [CH_N];

    // alpha zero or one passes the channel through
    assign p_bypass    = (p_alpha_reg == '0) || p_alpha_reg[FRAC_W];
    assign u_den       = {p_alpha_reg[FRAC_W-1:0], 1'b0};
    assign p_ctl.valid = p_valid_reg;

    for (genvar c = 0; c < CH_N; c++)
    begin : g_unmix
        logic            neg, ovf;
        logic [U_RW-1:0] dvd;
        logic            bypass_o, neg_o, ovf_o;

        assign neg = p_t_reg[c][28];
        assign dvd = neg ? '0 : p_t_reg[c][U_RW-1:0];
        // quotient of 512 or more is flagged before the cells and saturates at the end
        assign ovf = !neg && (dvd >= {1'b0, u_den, 9'b0});

        ctau_div_chain #(.RW(U_RW), .DW(U_DW), .QW(U_QW), .SW(U_SW)) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_ctl   (p_ctl),
            .in_rem   (dvd),
            .in_den   (u_den),
            .in_side  ({p_oa_reg, p_pix_reg[c], p_bypass, neg, ovf}),
            .out_ctl  (u_ctl[c]),
            .out_quot (u_quot[c]),
            .out_side (u_side[c])
        );

        assign bypass_o = u_side[c][2];
        assign neg_o    = u_side[c][1];
        assign ovf_o    = u_side[c][0];

        always_comb
        begin
            priority if (bypass_o)
                res[c] = u_side[c][3 +: CH_W];
            else if (neg_o)
                res[c] = '0;
            else if (ovf_o || u_quot[c][U_QW-1])
                res[c] = '1;
            else
                res[c] = u_quot[c][CH_W-1:0];
        end
    end

    // output register
    logic            done_reg;
    logic [CH_W-1:0] out_reg [CH_N];
    logic [CH_W-1:0] alpha_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= u_ctl[0].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        alpha_out_reg <= u_side[0][U_SW-1 -: CH_W];
        for (int i = 0; i < CH_N; i++)
        begin
            out_reg[i] <= res[i];
        end
    end

    assign done      = done_reg;
    assign out_red   = out_reg[0];
    assign out_green = out_reg[1];
    assign out_blue  = out_reg[2];
    assign out_alpha = alpha_out_reg;

    logic a_in_step, u_in_step, u_alpha_same;
    assign a_in_step    = (a_ctl[0].valid == a_ctl[1].valid)
                          && (a_ctl[0].valid == a_ctl[2].valid);
    assign u_in_step    = (u_ctl[0].valid == u_ctl[1].valid)
                          && (u_ctl[0].valid == u_ctl[2].valid);
    assign u_alpha_same = (u_side[0][U_SW-1 -: CH_W] == u_side[1][U_SW-1 -: CH_W])
                          && (u_side[0][U_SW-1 -: CH_W] == u_side[2][U_SW-1 -: CH_W]);

    // the three alpha rows advance in lockstep
    `CTAU_ASSERT(a_rows_lockstep, clk, rst_n, a_in_step, "alpha divider rows out of step")
    // the three unmix rows advance in lockstep
    `CTAU_ASSERT(u_rows_lockstep, clk, rst_n, u_in_step, "unmix divider rows out of step")
    // scaled alpha travels identically in every lane
    `CTAU_ASSERT_IMPL(u_alpha_agree, clk, rst_n, u_ctl[0].valid, u_alpha_same, "lanes disagree")
    // a finished word is strobed in the next cycle
    `CTAU_ASSERT_NEXT(u_to_done, clk, rst_n, u_ctl[0].valid, done, "result word dropped")
endmodule
`default_nettype wire

// ===== bench/color_to_alpha_unmix_top_test.sv =====
// testbench for the color to alpha unmix block: predicted rgba words checked in order
`timescale 1ns / 1ps
`default_nettype none
module color_to_alpha_unmix_top_test;
    import ctau_pkg::*;

    localparam int LATENCY     = 29;
    localparam int STALL_LIMIT = 2000;
    localparam int N_RANDOM    = 1600;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

    // holds the background copy and the queue of predicted rgba words
    class rgba_scoreboard;
        logic [7:0] bg[3];
        rgba_t      pending[$];
        int         errors;

        function new();
            bg[0] = 8'd255;
            bg[1] = 8'd255;
            bg[2] = 8'd255;
            errors = 0;
        endfunction

        // per-channel opacity, q1.16 with 65536 = one
        function longint chan_opacity(longint c, longint bk);
            longint num;
            longint den;
            if (c == bk) return 0;
            if (c < bk)
            begin
                num = bk - c;
                den = bk;
            end
            else
            begin
                num = c - bk;
                den = 255 - bk;
            end
            if (den == 0) return 65536;
            return (num * 65536 + den / 2) / den;
        endfunction

        function logic [7:0] unmixed(longint a, longint c, longint bk);
            longint v;
            longint t;
            longint q;
            if (a == 0 || a >= 65536) return c[7:0];
            v = (c - bk) * 65536 + bk * a;
            t = 2 * v + a;
            if (t < 0) return 8'd0;
            q = t / (2 * a);
            return (q > 255) ? 8'd255 : q[7:0];
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            longint a;
            longint ag;
            longint ab;
            longint sa;
            rgba_t  w;
            a  = chan_opacity(r, bg[0]);
            ag = chan_opacity(g, bg[1]);
            ab = chan_opacity(b, bg[2]);
            if (ag > a) a = ag;
            if (ab > a) a = ab;
            w.r = unmixed(a, r, bg[0]);
            w.g = unmixed(a, g, bg[1]);
            w.b = unmixed(a, b, bg[2]);
            sa  = (a * 255 + 32768) >> 16;
            w.a = sa[7:0];
            pending.insert(pending.size(), w);
        endfunction

        function void check_word(rgba_t got);
            rgba_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.r !== want.r)
            begin
                $display("%0t: out_red expected %0d actual %0d", $time, want.r, got.r);
                errors++;
            end
            if (got.g !== want.g)
            begin
                $display("%0t: out_green expected %0d actual %0d", $time, want.g, got.g);
                errors++;
            end
            if (got.b !== want.b)
            begin
                $display("%0t: out_blue expected %0d actual %0d", $time, want.b, got.b);
                errors++;
            end
            if (got.a !== want.a)
            begin
                $display("%0t: out_alpha expected %0d actual %0d", $time, want.a, got.a);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [7:0] red = '0;
    logic [7:0] green = '0;
    logic [7:0] blue = '0;
    logic       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       done;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    rgba_scoreboard sb = new();
    int sender_gap_pct = 0;
    int idle_cycles = 0;

    color_to_alpha_unmix_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .red(red), .green(green), .blue(blue),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .out_red(out_red), .out_green(out_green),
        .out_blue(out_blue), .out_alpha(out_alpha)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: a word is accepted at the edge that ends its strobe cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_word({out_red, out_green, out_blue, out_alpha});
    end

    // watchdog: cycles in which neither side moves a word
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("color_to_alpha_unmix_top test failed");
            $finish;
        end
    end

    // offer one pixel word, with random sender gaps before it
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        red   <= r;
        green <= g;
        blue  <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_pixel(r, g, b);
    endtask

    // drain the pipeline, then write one background register
    task automatic write_bg(input cfg_idx_t idx, input logic [7:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.bg[idx] = v;
    endtask

    task automatic set_bg(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        write_bg(CFG_BG_RED, r);
        write_bg(CFG_BG_GREEN, g);
        write_bg(CFG_BG_BLUE, b);
    endtask

    // mostly pixels close to the background so alpha lands in the middle range
    task automatic random_pixels(input int n);
        logic [7:0] p[3];
        int d;
        for (int i = 0; i < n; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if ($urandom_range(3) == 0)
                    p[c] = 8'($urandom_range(255));
                else if ($urandom_range(7) == 0)
                    p[c] = sb.bg[c];
                else
                begin
                    d = int'(sb.bg[c]) + int'($urandom_range(60)) - 30;
                    p[c] = (d < 0) ? 8'd0 : (d > 255) ? 8'd255 : d[7:0];
                end
            end
            send_pixel(p[0], p[1], p[2]);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: white background at reset, pixel equal to background, extremes
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd128, 8'd64, 8'd200);
        send_pixel(8'd254, 8'd1, 8'd255);
        // black background: lighter branch only, alpha one for white channels
        set_bg(8'd0, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd10, 8'd20);
        send_pixel(8'd1, 8'd2, 8'd3);
        send_pixel(8'd170, 8'd85, 8'd255);
        // mid-gray background: both branches, rounding overshoot
        set_bg(8'd128, 8'd127, 8'd1);
        send_pixel(8'd128, 8'd127, 8'd1);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd129, 8'd126, 8'd2);
        send_pixel(8'd255, 8'd0, 8'd254);
        send_pixel(8'd100, 8'd150, 8'd1);
        set_bg(8'd254, 8'd1, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd128);
        send_pixel(8'd253, 8'd2, 8'd0);

        // random phases: sender gaps 7 percent, then 46, then none
        sender_gap_pct = 7;
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 3) sender_gap_pct = 46;
            if (ph == 6) sender_gap_pct = 0;
            set_bg(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
            random_pixels(N_RANDOM / 8);
        end

        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (sb.errors == 0)
            $display("color_to_alpha_unmix_top test passed");
        else
            $display("color_to_alpha_unmix_top test failed");
        $finish;
    end
endmodule
`default_nettype wire
